// ===== hw/rtl/pixel_format_to_rgba8888_unit_assert.svh =====
// Assertion shorthands, all sampled on clk and quiet during rst.
`ifndef PIXEL_FORMAT_TO_RGBA8888_UNIT_ASSERT_SVH
`define PIXEL_FORMAT_TO_RGBA8888_UNIT_ASSERT_SVH

// same-cycle implication
`define PF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/pfrgba_pkg.sv =====
package pfrgba_pkg;

  typedef enum logic [3:0] {
    FMT_565       = 4'd0,
    FMT_5551      = 4'd1,
    FMT_4444      = 4'd2,
    FMT_8888      = 4'd3,
    FMT_FLOAT     = 4'd4,
    FMT_D16       = 4'd5,
    FMT_S8        = 4'd6,
    FMT_D24LO     = 4'd7,
    FMT_S8HI      = 4'd8,
    FMT_D24BIAS   = 4'd9,
    FMT_FLOATBIAS = 4'd10
  } pix_fmt_t;

  typedef enum logic [1:0] {
    REG_PIXEL_FORMAT  = 2'd0,
    REG_BYTE_REVERSE  = 2'd1,
    REG_RED_BLUE_SWAP = 2'd2,
    REG_ALPHA_OUT     = 2'd3
  } reg_idx_t;

  // classification of the float word, carried down the pipe
  typedef struct packed {
    logic nan;
    logic neg;
    logic ge_one;  // exponent says |f| >= 1
    logic big;     // exponent says |f| >= 2^23
  } flt_flags_t;

  localparam pix_fmt_t  FMT_RESET  = FMT_8888;
  localparam logic [7:0] EXP_ONE    = 8'd127;
  localparam logic [7:0] EXP_BIG    = 8'd150;
  localparam logic [7:0] EXP_MAX    = 8'hFF;
  localparam logic [7:0] SHIFT_DEN  = 8'd149;
  localparam logic [7:0] BIAS_FLIP  = 8'h80;

  function automatic logic [7:0] widen5(input logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  function automatic logic [7:0] widen6(input logic [5:0] v);
    return {v, v[5:4]};
  endfunction

  function automatic logic [7:0] widen4(input logic [3:0] v);
    return {v, v};
  endfunction

endpackage

// ===== hw/rtl/pixel_format_to_rgba8888_unit.sv =====
// Converts one raw framebuffer word per cycle into RGBA8888 bytes, while in_stall
// is low. Four register stages (input, float scale, float shift, output) carry
// each word to out_valid, and a new word can be taken every cycle while in_stall
// is low. Stalls back up stage by stage, so empty stages keep accepting while
// the output waits.
// Registers at byte address 4*i: pixel_format, byte_reverse, red_blue_swap,
// alpha_out; change them only while the pipe is empty. Unsupported formats give
// zero bytes with format_error set.
`include "pixel_format_to_rgba8888_unit_assert.svh"

module pixel_format_to_rgba8888_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] raw_pixel,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte0,
  output logic [7:0]  out_byte1,
  output logic [7:0]  out_byte2,
  output logic [7:0]  out_byte3,
  output logic        format_error,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import pfrgba_pkg::*;

  pix_fmt_t pixel_format;
  logic     byte_reverse;
  logic     red_blue_swap;
  logic     alpha_out;

  reg_idx_t reg_sel;
  logic     cfg_wr;

  // stage 1: input word
  logic        s1_valid;
  logic [31:0] s1_raw;
  // stage 2: scaled mantissa
  logic        s2_valid;
  logic [31:0] s2_raw;
  logic [31:0] s2_prod_a;
  logic [47:0] s2_prod_d;
  logic [7:0]  s2_shift;
  flt_flags_t  s2_flags;
  // stage 3: shifted results
  logic        s3_valid;
  logic [31:0] s3_raw;
  logic [7:0]  s3_flt_alpha;
  logic [15:0] s3_mag;
  logic        s3_sat;
  flt_flags_t  s3_flags;

  logic out_ready, s3_ready, s2_ready, s1_ready;

  // stage 1 comb
  logic [7:0]  s1_exp;
  logic [22:0] s1_frac;
  logic [23:0] s1_mant;
  logic [31:0] s1_prod_a;
  logic [47:0] s1_prod_d;
  logic [7:0]  s1_shift;
  flt_flags_t  s1_flags;

  // stage 2 comb
  logic [7:0]  s2_alpha_sh;
  logic [7:0]  s2_flt_alpha;
  logic [47:0] s2_mag;

  // stage 3 comb
  logic [15:0] s3_depth16;
  logic [15:0] s3_s16;
  logic [31:0] s3_raw32;
  logic [7:0]  r, g, b, a;
  logic        colour, err;
  logic [7:0]  b0_next, b1_next, b2_next, b3_next;

  // checks
  logic out_zero;
  logic pipe_full;

  // ---------------- configuration port ----------------
  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format  <= FMT_RESET;
      byte_reverse  <= 1'b0;
      red_blue_swap <= 1'b0;
      alpha_out     <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_PIXEL_FORMAT:  pixel_format  <= pix_fmt_t'(pwdata[3:0]);
        REG_BYTE_REVERSE:  byte_reverse  <= pwdata[0];
        REG_RED_BLUE_SWAP: red_blue_swap <= pwdata[0];
        REG_ALPHA_OUT:     alpha_out     <= pwdata[0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_PIXEL_FORMAT:  prdata = {28'd0, pixel_format};
      REG_BYTE_REVERSE:  prdata = {31'd0, byte_reverse};
      REG_RED_BLUE_SWAP: prdata = {31'd0, red_blue_swap};
      REG_ALPHA_OUT:     prdata = {31'd0, alpha_out};
    endcase
  end

  // ---------------- flow control ----------------
  assign out_ready = !out_valid || !out_stall;
  assign s3_ready  = !s3_valid || out_ready;
  assign s2_ready  = !s2_valid || s3_ready;
  assign s1_ready  = !s1_valid || s2_ready;
  assign in_stall  = !s1_ready;

  // ---------------- stage 1 ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_raw <= raw_pixel;
    end
  end

  // mantissa times 255 and times 2^24-1, plus the right shift that scales it
  always_comb begin
    s1_exp          = s1_raw[30:23];
    s1_frac         = s1_raw[22:0];
    s1_mant         = {(s1_exp != 8'd0), s1_frac};
    s1_prod_a       = {s1_mant, 8'd0} - {8'd0, s1_mant};
    s1_prod_d       = {s1_mant, 24'd0} - {24'd0, s1_mant};
    s1_shift        = (s1_exp == 8'd0) ? SHIFT_DEN : EXP_BIG - s1_exp;
    s1_flags.nan    = (s1_exp == EXP_MAX) && (s1_frac != 23'd0);
    s1_flags.neg    = s1_raw[31];
    s1_flags.ge_one = (s1_exp >= EXP_ONE);
    s1_flags.big    = (s1_exp >= EXP_BIG);
  end

  // ---------------- stage 2 ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      s2_raw    <= s1_raw;
      s2_prod_a <= s1_prod_a;
      s2_prod_d <= s1_prod_d;
      s2_shift  <= s1_shift;
      s2_flags  <= s1_flags;
    end
  end

  always_comb begin
    s2_alpha_sh = 8'(s2_prod_a >> s2_shift);
    s2_mag      = s2_prod_d >> s2_shift;
    priority if (s2_flags.nan || s2_flags.neg) begin
      s2_flt_alpha = 8'd0;
    end else if (s2_flags.ge_one) begin
      s2_flt_alpha = 8'hFF;
    end else begin
      s2_flt_alpha = s2_alpha_sh;
    end
  end

  // ---------------- stage 3 ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_ready) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready && s2_valid) begin
      s3_raw       <= s2_raw;
      s3_flt_alpha <= s2_flt_alpha;
      s3_mag       <= s2_mag[15:0];
      s3_sat       <= |s2_mag[47:31];
      s3_flags     <= s2_flags;
    end
  end

  // low half of the saturated signed depth; only bits 8..15 reach alpha
  always_comb begin
    priority if (s3_flags.nan) begin
      s3_depth16 = 16'd0;
    end else if (s3_flags.big || s3_sat) begin
      s3_depth16 = s3_flags.neg ? 16'h0000 : 16'hFFFF;
    end else if (s3_flags.neg) begin
      s3_depth16 = 16'd0 - s3_mag;
    end else begin
      s3_depth16 = s3_mag;
    end
  end

  always_comb begin
    s3_s16   = byte_reverse ? {s3_raw[7:0], s3_raw[15:8]} : s3_raw[15:0];
    s3_raw32 = (byte_reverse && pixel_format == FMT_8888) ?
               {s3_raw[7:0], s3_raw[15:8], s3_raw[23:16], s3_raw[31:24]} : s3_raw;
    colour = 1'b0;
    err    = 1'b0;
    r      = 8'hFF;
    g      = 8'd0;
    b      = 8'd0;
    a      = 8'd0;
    unique case (pixel_format)
      FMT_565: begin
        colour = 1'b1;
        a = 8'hFF;
        r = widen5(s3_s16[4:0]);
        g = widen6(s3_s16[10:5]);
        b = widen5(s3_s16[15:11]);
      end
      FMT_5551: begin
        colour = 1'b1;
        a = {8{s3_s16[15]}};
        r = widen5(s3_s16[4:0]);
        g = widen5(s3_s16[9:5]);
        b = widen5(s3_s16[14:10]);
      end
      FMT_4444: begin
        colour = 1'b1;
        a = widen4(s3_s16[15:12]);
        r = widen4(s3_s16[3:0]);
        g = widen4(s3_s16[7:4]);
        b = widen4(s3_s16[11:8]);
      end
      FMT_8888: begin
        colour = 1'b1;
        a = s3_raw32[31:24];
        r = s3_raw32[7:0];
        g = s3_raw32[15:8];
        b = s3_raw32[23:16];
      end
      FMT_FLOAT:     a = s3_flt_alpha;
      FMT_D16:       a = s3_raw[15:8];
      FMT_S8:        a = s3_raw[7:0];
      FMT_D24LO:     a = s3_raw[23:16];
      FMT_S8HI:      a = s3_raw[31:24];
      // -0x800000 + 0x8000 only flips bit 15 of the low half
      FMT_D24BIAS:   a = s3_raw[15:8] ^ BIAS_FLIP;
      FMT_FLOATBIAS: a = s3_depth16[15:8] ^ BIAS_FLIP;
      default: begin
        err = 1'b1;
        r   = 8'd0;
      end
    endcase

    b1_next = g;
    if (colour && red_blue_swap) begin
      b0_next = b;
      b2_next = r;
    end else begin
      b0_next = r;
      b2_next = b;
    end
    b3_next = a;
    // no alpha byte: depth alpha overwrites red, colour red wins
    if (!alpha_out) begin
      if (!colour && !err) begin
        b0_next = a;
      end
      b3_next = 8'd0;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && s3_valid) begin
      out_byte0    <= b0_next;
      out_byte1    <= b1_next;
      out_byte2    <= b2_next;
      out_byte3    <= b3_next;
      format_error <= err;
    end
  end

  // ---------------- checks ----------------
  assign out_zero  = ~|{out_byte0, out_byte1, out_byte2, out_byte3};
  assign pipe_full = s1_valid && s2_valid && s3_valid && out_valid;

  `PF_ASSERT_NOW(a_err_zero, out_valid && format_error, out_zero, "error word not zero")
  `PF_ASSERT_NOW(a_no_alpha, out_valid && !alpha_out, out_byte3 == 8'd0, "alpha byte set")
  `PF_ASSERT_NEXT(a_s1_hold, s1_valid && !s2_ready, s1_valid, "stage 1 word dropped")
  `PF_ASSERT_NOW(a_stall_full, in_stall, pipe_full, "input stalled with an empty stage")

endmodule
